// ===== sv/dpr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the distorted pinhole residual block.
package dpr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NORM_BITS = 28;
    localparam int DIV_STEPS = 33;
    localparam int DIV_TAG_W = 67;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_K1       = 3'd4;
    localparam logic [2:0] CFG_K2       = 3'd5;
    localparam logic [2:0] CFG_P1       = 3'd6;
    localparam logic [2:0] CFG_P2       = 3'd7;

    localparam logic [30:0] FOCAL_RST  = 31'(500 << FRAC_BITS);
    localparam logic [30:0] CENTER_RST = 31'(320 << FRAC_BITS);

    localparam logic [31:0] SIXTH_ORDER_COEFF = 32'sd0;
    localparam logic [31:0] ONE_N      = 32'(1 << NORM_BITS);
    localparam logic [31:0] NEG_ONE_N  = 32'(-(1 << NORM_BITS));
    localparam logic [31:0] INT32_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN  = 32'h8000_0000;

    typedef struct packed {
        logic        clip;
        logic [31:0] val;
    } sat_t;

    function automatic sat_t sat_w(input logic [65:0] v);
        sat_t r;
        if ((&v[65:31]) || !(|v[65:31])) begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end else begin
            r.clip = 1'b1;
            r.val  = v[65] ? INT32_MIN : INT32_MAX;
        end
        return r;
    endfunction

    function automatic logic [65:0] sx66(input logic [31:0] a);
        return {{34{a[31]}}, a};
    endfunction

    function automatic sat_t add_sat(input logic [31:0] a, input logic [31:0] b);
        return sat_w(sx66(a) + sx66(b));
    endfunction

    function automatic sat_t sub_sat(input logic [31:0] a, input logic [31:0] b);
        return sat_w(sx66(a) - sx66(b));
    endfunction

    function automatic sat_t add2_sat(input logic [31:0] a, input logic [31:0] b);
        return sat_w(sx66(a) + {{33{b[31]}}, b, 1'b0});
    endfunction

    function automatic sat_t qsh(input logic [63:0] p);
        return sat_w({{30{p[63]}}, p[63:NORM_BITS]});
    endfunction

    function automatic logic [63:0] smul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] r;
        r = $signed(a) * $signed(b);
        return r;
    endfunction

    function automatic logic [63:0] emul(input logic [32:0] e, input logic [30:0] c);
        logic signed [63:0] r;
        r = $signed(e) * $signed({1'b0, c});
        return r;
    endfunction

    function automatic sat_t q_fix(input logic [DIV_STEPS-1:0] qmag, input logic ovf,
                                   input logic neg, input logic [65:0] bias);
        logic [65:0] q;
        sat_t        r;
        q = {33'b0, qmag};
        if (neg) begin
            q = ~q + 66'd1;
        end
        r = sat_w(q - bias);
        if (ovf) begin
            r.clip = 1'b1;
            r.val  = neg ? INT32_MIN : INT32_MAX;
        end
        return r;
    endfunction

endpackage

// ===== sv/dpr_div.sv =====
// Pipelined restoring divider: one quotient bit per stage with overflow precheck.
module dpr_div import dpr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [63:0]           num,
    input  logic [31:0]           den,
    input  logic [DIV_TAG_W-1:0]  in_tag,
    output logic                  out_valid,
    output logic [DIV_STEPS-1:0]  quo,
    output logic                  ovf,
    output logic [DIV_TAG_W-1:0]  out_tag
);

    logic [DIV_STEPS-1:0] vld_reg;
    logic [31:0]          rem_reg [DIV_STEPS];
    logic [32:0]          low_reg [DIV_STEPS];
    logic [32:0]          quo_reg [DIV_STEPS];
    logic [31:0]          den_reg [DIV_STEPS];
    logic                 ovf_reg [DIV_STEPS];
    logic [DIV_TAG_W-1:0] tag_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [31:0]          rem_in;
        logic [31:0]          d_in;
        logic [32:0]          low_in;
        logic [32:0]          quo_in;
        logic                 ovf_in;
        logic [DIV_TAG_W-1:0] tag_in;
        logic [32:0]          trial;
        logic [33:0]          diff;

        if (k == 0) begin : g_first
            assign rem_in = {1'b0, num[63:33]};
            assign low_in = num[32:0];
            assign quo_in = '0;
            assign d_in   = den;
            assign ovf_in = ({1'b0, num[63:33]} >= den);
            assign tag_in = in_tag;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign d_in   = den_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign trial = {rem_in, low_in[32]};
        assign diff  = {1'b0, trial} - {2'b0, d_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= diff[33] ? trial[31:0] : diff[31:0];
                low_reg[k] <= {low_in[31:0], 1'b0};
                quo_reg[k] <= {quo_in[31:0], ~diff[33]};
                den_reg[k] <= d_in;
                ovf_reg[k] <= ovf_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quo       = quo_reg[DIV_STEPS-1];
    assign ovf       = ovf_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];

endmodule

// ===== sv/distorted_pinhole_residual.sv =====
// Top level: pinhole projection with lens distortion, giving the pixel residual per point.
// Usage:
//   Input beats (s_valid/s_ready) carry one camera-frame point and its observed pixel.
//   Result beats (m_valid/m_ready) carry residual_u, residual_v and the saturated flag,
//   one result per input beat, in order.
//   Configuration registers are written through cfg_we/cfg_addr/cfg_wdata, one per cycle;
//   the user must write them only while no beat is in flight; the block does not enforce this.
// Throughput: one beat per cycle while the output is not stalled.
//   The two 33-stage divider pipelines (depth, then center) make up most of the pipeline.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads focal 500.0,
//   center 320.0 and zero distortion coefficients.
// Stall: while a result waits with m_ready low, the whole pipeline holds and s_ready
//   drops; nothing is lost or repeated. Bubbles travel as invalid stages.
module distorted_pinhole_residual import dpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_point_x,
    input  logic [31:0] s_point_y,
    input  logic [31:0] s_point_z,
    input  logic [31:0] s_observed_u,
    input  logic [31:0] s_observed_v,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_residual_u,
    output logic [31:0] m_residual_v,
    output logic        m_saturated
);

    logic [30:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [31:0] k1_reg, k2_reg, p1_reg, p2_reg;

    logic        adv;
    logic [2:0]  vlda_reg;
    logic [1:0]  vldb_reg;
    logic [18:0] vldc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= FOCAL_RST;
            focal_y_reg  <= FOCAL_RST;
            center_x_reg <= CENTER_RST;
            center_y_reg <= CENTER_RST;
            k1_reg       <= '0;
            k2_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FOCAL_X:  focal_x_reg  <= cfg_wdata[30:0];
                CFG_FOCAL_Y:  focal_y_reg  <= cfg_wdata[30:0];
                CFG_CENTER_X: center_x_reg <= cfg_wdata[30:0];
                CFG_CENTER_Y: center_y_reg <= cfg_wdata[30:0];
                CFG_K1:       k1_reg       <= cfg_wdata;
                CFG_K2:       k2_reg       <= cfg_wdata;
                CFG_P1:       p1_reg       <= cfg_wdata;
                CFG_P2:       p2_reg       <= cfg_wdata;
            endcase
        end
    end

    assign adv     = !vldc_reg[18] || m_ready;
    assign s_ready = adv;
    assign m_valid = vldc_reg[18];

    // projection numerator
    logic [63:0] s1_czu_reg, s1_fxu_reg, s1_czv_reg, s1_fyv_reg;
    logic [31:0] s1_z_reg, s1_ou_reg, s1_ov_reg;
    logic [63:0] s2_numu_reg, s2_numv_reg;
    logic [31:0] s2_z_reg, s2_ou_reg, s2_ov_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_czu_reg  <= smul({1'b0, center_x_reg}, s_point_z);
            s1_fxu_reg  <= smul({1'b0, focal_x_reg}, s_point_x);
            s1_czv_reg  <= smul({1'b0, center_y_reg}, s_point_z);
            s1_fyv_reg  <= smul({1'b0, focal_y_reg}, s_point_y);
            s1_z_reg    <= s_point_z;
            s1_ou_reg   <= s_observed_u;
            s1_ov_reg   <= s_observed_v;
            s2_numu_reg <= s1_czu_reg + s1_fxu_reg;
            s2_numv_reg <= s1_czv_reg + s1_fyv_reg;
            s2_z_reg    <= s1_z_reg;
            s2_ou_reg   <= s1_ou_reg;
            s2_ov_reg   <= s1_ov_reg;
        end
    end

    // magnitudes and zero-depth path
    logic [63:0] s3_magu_reg, s3_magv_reg;
    logic [31:0] s3_zmag_reg, s3_ou_reg, s3_ov_reg;
    logic        s3_sgnu_reg, s3_sgnv_reg, s3_zero_reg;
    sat_t        s3_upz_reg, s3_vpz_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_magu_reg <= s2_numu_reg[63] ? (~s2_numu_reg + 64'd1) : s2_numu_reg;
            s3_magv_reg <= s2_numv_reg[63] ? (~s2_numv_reg + 64'd1) : s2_numv_reg;
            s3_zmag_reg <= s2_z_reg[31] ? (~s2_z_reg + 32'd1) : s2_z_reg;
            s3_sgnu_reg <= s2_numu_reg[63] ^ s2_z_reg[31];
            s3_sgnv_reg <= s2_numv_reg[63] ^ s2_z_reg[31];
            s3_zero_reg <= (s2_z_reg == '0);
            s3_upz_reg  <= sat_w({{(FRAC_BITS+2){s2_numu_reg[63]}},
                                  s2_numu_reg[63:FRAC_BITS]});
            s3_vpz_reg  <= sat_w({{(FRAC_BITS+2){s2_numv_reg[63]}},
                                  s2_numv_reg[63:FRAC_BITS]});
            s3_ou_reg   <= s2_ou_reg;
            s3_ov_reg   <= s2_ov_reg;
        end
    end

    // divide by depth
    logic                 d1u_valid, d1v_valid, d1u_ovf, d1v_ovf;
    logic [DIV_STEPS-1:0] d1u_quo, d1v_quo;
    logic [DIV_TAG_W-1:0] d1u_tag, d1v_tag;

    dpr_div u_div_pu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vlda_reg[2]),
        .num       (s3_magu_reg),
        .den       (s3_zmag_reg),
        .in_tag    ({s3_sgnu_reg, s3_zero_reg, s3_upz_reg, s3_ou_reg}),
        .out_valid (d1u_valid),
        .quo       (d1u_quo),
        .ovf       (d1u_ovf),
        .out_tag   (d1u_tag)
    );

    dpr_div u_div_pv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vlda_reg[2]),
        .num       (s3_magv_reg),
        .den       (s3_zmag_reg),
        .in_tag    ({s3_sgnv_reg, s3_zero_reg, s3_vpz_reg, s3_ov_reg}),
        .out_valid (d1v_valid),
        .quo       (d1v_quo),
        .ovf       (d1v_ovf),
        .out_tag   (d1v_tag)
    );

    sat_t        up_c, vp_c;
    logic [31:0] s4_up_reg, s4_vp_reg, s4_ou_reg, s4_ov_reg;
    logic        s4_fu_reg, s4_fv_reg;
    logic [31:0] s5_umag_reg, s5_vmag_reg, s5_ou_reg, s5_ov_reg;
    logic        s5_sgnu_reg, s5_sgnv_reg, s5_fu_reg, s5_fv_reg;

    always_comb begin
        up_c = d1u_tag[65] ? sat_t'(d1u_tag[64:32]) : q_fix(d1u_quo, d1u_ovf, d1u_tag[66], '0);
        vp_c = d1v_tag[65] ? sat_t'(d1v_tag[64:32]) : q_fix(d1v_quo, d1v_ovf, d1v_tag[66], '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_up_reg   <= up_c.val;
            s4_vp_reg   <= vp_c.val;
            s4_fu_reg   <= up_c.clip;
            s4_fv_reg   <= vp_c.clip;
            s4_ou_reg   <= d1u_tag[31:0];
            s4_ov_reg   <= d1v_tag[31:0];
            s5_umag_reg <= s4_up_reg[31] ? (~s4_up_reg + 32'd1) : s4_up_reg;
            s5_vmag_reg <= s4_vp_reg[31] ? (~s4_vp_reg + 32'd1) : s4_vp_reg;
            s5_sgnu_reg <= s4_up_reg[31];
            s5_sgnv_reg <= s4_vp_reg[31];
            s5_fu_reg   <= s4_fu_reg;
            s5_fv_reg   <= s4_fv_reg;
            s5_ou_reg   <= s4_ou_reg;
            s5_ov_reg   <= s4_ov_reg;
        end
    end

    // divide by center
    logic                 d2u_valid, d2v_valid, d2u_ovf, d2v_ovf;
    logic [DIV_STEPS-1:0] d2u_quo, d2v_quo;
    logic [DIV_TAG_W-1:0] d2u_tag, d2v_tag;

    dpr_div u_div_nu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vldb_reg[1]),
        .num       ({{(32-NORM_BITS){1'b0}}, s5_umag_reg, {NORM_BITS{1'b0}}}),
        .den       ({1'b0, center_x_reg}),
        .in_tag    ({{(DIV_TAG_W-34){1'b0}}, s5_sgnu_reg, s5_fu_reg, s5_ou_reg}),
        .out_valid (d2u_valid),
        .quo       (d2u_quo),
        .ovf       (d2u_ovf),
        .out_tag   (d2u_tag)
    );

    dpr_div u_div_nv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vldb_reg[1]),
        .num       ({{(32-NORM_BITS){1'b0}}, s5_vmag_reg, {NORM_BITS{1'b0}}}),
        .den       ({1'b0, center_y_reg}),
        .in_tag    ({{(DIV_TAG_W-34){1'b0}}, s5_sgnv_reg, s5_fv_reg, s5_ov_reg}),
        .out_valid (d2v_valid),
        .quo       (d2v_quo),
        .ovf       (d2v_ovf),
        .out_tag   (d2v_tag)
    );

    // normalized coordinates and distortion
    sat_t s_c, t_c;

    always_comb begin
        s_c = (center_x_reg == '0) ? sat_t'({1'b1, NEG_ONE_N})
                                   : q_fix(d2u_quo, d2u_ovf, d2u_tag[33], sx66(ONE_N));
        t_c = (center_y_reg == '0) ? sat_t'({1'b1, NEG_ONE_N})
                                   : q_fix(d2v_quo, d2v_ovf, d2v_tag[33], sx66(ONE_N));
    end

    logic [31:0] s_dl_reg [12];
    logic [31:0] t_dl_reg [12];
    logic [31:0] ou_dl_reg [18];
    logic [31:0] ov_dl_reg [18];
    logic        f6_reg, f7_reg, f8_reg, f9_reg, f10_reg, f11_reg, f12_reg, f13_reg;
    logic        f14_reg, f15_reg, f16_reg, f17_reg, f18_reg, f19_reg, f20_reg, f21_reg;
    logic        f22_reg, f23_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_dl_reg[0]  <= s_c.val;
            t_dl_reg[0]  <= t_c.val;
            ou_dl_reg[0] <= d2u_tag[31:0];
            ov_dl_reg[0] <= d2v_tag[31:0];
            for (int i = 1; i < 12; i++) begin
                s_dl_reg[i] <= s_dl_reg[i-1];
                t_dl_reg[i] <= t_dl_reg[i-1];
            end
            for (int i = 1; i < 18; i++) begin
                ou_dl_reg[i] <= ou_dl_reg[i-1];
                ov_dl_reg[i] <= ov_dl_reg[i-1];
            end
            f6_reg <= d2u_tag[32] | d2v_tag[32] | s_c.clip | t_c.clip;
        end
    end

    logic [63:0] pss_reg, ptt_reg, pst_reg;
    logic [31:0] x2_8_reg, y2_8_reg, st_8_reg;
    logic [31:0] r2_9_reg, x2_9_reg, y2_9_reg, st_9_reg;
    logic [63:0] pr4_10_reg;
    logic [31:0] r2_10_reg, tx_10_reg, ty_10_reg, st_10_reg;
    logic [31:0] r4_11_reg, r2_11_reg, tx_11_reg, ty_11_reg, st_11_reg;
    logic [63:0] pk1_11_reg;
    logic [63:0] pr6_12_reg, pk2_12_reg;
    logic [31:0] k1r2_12_reg, tx_12_reg, ty_12_reg, st_12_reg;
    logic [31:0] r6_13_reg, kr_13_reg, tx_13_reg, ty_13_reg, st_13_reg;
    logic [63:0] pk3_14_reg;
    logic [31:0] kr_14_reg, tx_14_reg, ty_14_reg, st_14_reg;
    logic [31:0] kr_15_reg, tx_15_reg, ty_15_reg, st_15_reg;
    logic [63:0] psk_16_reg, ptk_16_reg, pp2tx_16_reg, pp1ty_16_reg, pp1st_16_reg;
    logic [63:0] pp2st_16_reg;
    logic [31:0] skr_17_reg, tkr_17_reg, p2tx_17_reg, p1ty_17_reg, p1st_17_reg;
    logic [31:0] p2st_17_reg;
    logic [31:0] xd_18_reg, yd_18_reg, p2tx_18_reg, p1ty_18_reg, p1st_18_reg, p2st_18_reg;
    logic [31:0] xd_19_reg, yd_19_reg, p1st_19_reg, p2st_19_reg;
    logic [31:0] xd_20_reg, yd_20_reg;
    logic [32:0] eu_21_reg, ev_21_reg;
    logic [63:0] pu_22_reg, pv_22_reg;
    logic [31:0] pu_23_reg, pv_23_reg;
    logic [31:0] ru_reg, rv_reg;
    logic        sat_out_reg;

    sat_t x2_c, y2_c, st_c, r2_c, tx_c, ty_c, r4_c, k1r2_c, r6_c, k2r4_c, kr13_c;
    sat_t k3r6_c, kr15_c, skr_c, tkr_c, p2tx_c, p1ty_c, p1st_c, p2st_c;
    sat_t xd18_c, yd18_c, xd19_c, yd19_c, xd20_c, yd20_c, pu_c, pv_c, ru_c, rv_c;

    always_comb begin
        x2_c   = qsh(pss_reg);
        y2_c   = qsh(ptt_reg);
        st_c   = qsh(pst_reg);
        r2_c   = add_sat(x2_8_reg, y2_8_reg);
        tx_c   = add2_sat(r2_9_reg, x2_9_reg);
        ty_c   = add2_sat(r2_9_reg, y2_9_reg);
        r4_c   = qsh(pr4_10_reg);
        k1r2_c = qsh(pk1_11_reg);
        r6_c   = qsh(pr6_12_reg);
        k2r4_c = qsh(pk2_12_reg);
        kr13_c = add_sat(k1r2_12_reg, k2r4_c.val);
        k3r6_c = qsh(pk3_14_reg);
        kr15_c = add_sat(kr_14_reg, k3r6_c.val);
        skr_c  = qsh(psk_16_reg);
        tkr_c  = qsh(ptk_16_reg);
        p2tx_c = qsh(pp2tx_16_reg);
        p1ty_c = qsh(pp1ty_16_reg);
        p1st_c = qsh(pp1st_16_reg);
        p2st_c = qsh(pp2st_16_reg);
        xd18_c = add_sat(s_dl_reg[11], skr_17_reg);
        yd18_c = add_sat(t_dl_reg[11], tkr_17_reg);
        xd19_c = add_sat(xd_18_reg, p2tx_18_reg);
        yd19_c = add_sat(yd_18_reg, p1ty_18_reg);
        xd20_c = add2_sat(xd_19_reg, p1st_19_reg);
        yd20_c = add2_sat(yd_19_reg, p2st_19_reg);
        pu_c   = qsh(pu_22_reg);
        pv_c   = qsh(pv_22_reg);
        ru_c   = sub_sat(pu_23_reg, ou_dl_reg[17]);
        rv_c   = sub_sat(pv_23_reg, ov_dl_reg[17]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pss_reg      <= smul(s_dl_reg[0], s_dl_reg[0]);
            ptt_reg      <= smul(t_dl_reg[0], t_dl_reg[0]);
            pst_reg      <= smul(s_dl_reg[0], t_dl_reg[0]);
            f7_reg       <= f6_reg;

            x2_8_reg     <= x2_c.val;
            y2_8_reg     <= y2_c.val;
            st_8_reg     <= st_c.val;
            f8_reg       <= f7_reg | x2_c.clip | y2_c.clip | st_c.clip;

            r2_9_reg     <= r2_c.val;
            x2_9_reg     <= x2_8_reg;
            y2_9_reg     <= y2_8_reg;
            st_9_reg     <= st_8_reg;
            f9_reg       <= f8_reg | r2_c.clip;

            pr4_10_reg   <= smul(r2_9_reg, r2_9_reg);
            r2_10_reg    <= r2_9_reg;
            tx_10_reg    <= tx_c.val;
            ty_10_reg    <= ty_c.val;
            st_10_reg    <= st_9_reg;
            f10_reg      <= f9_reg | tx_c.clip | ty_c.clip;

            r4_11_reg    <= r4_c.val;
            pk1_11_reg   <= smul(k1_reg, r2_10_reg);
            r2_11_reg    <= r2_10_reg;
            tx_11_reg    <= tx_10_reg;
            ty_11_reg    <= ty_10_reg;
            st_11_reg    <= st_10_reg;
            f11_reg      <= f10_reg | r4_c.clip;

            pr6_12_reg   <= smul(r2_11_reg, r4_11_reg);
            pk2_12_reg   <= smul(k2_reg, r4_11_reg);
            k1r2_12_reg  <= k1r2_c.val;
            tx_12_reg    <= tx_11_reg;
            ty_12_reg    <= ty_11_reg;
            st_12_reg    <= st_11_reg;
            f12_reg      <= f11_reg | k1r2_c.clip;

            r6_13_reg    <= r6_c.val;
            kr_13_reg    <= kr13_c.val;
            tx_13_reg    <= tx_12_reg;
            ty_13_reg    <= ty_12_reg;
            st_13_reg    <= st_12_reg;
            f13_reg      <= f12_reg | r6_c.clip | k2r4_c.clip | kr13_c.clip;

            pk3_14_reg   <= smul(SIXTH_ORDER_COEFF, r6_13_reg);
            kr_14_reg    <= kr_13_reg;
            tx_14_reg    <= tx_13_reg;
            ty_14_reg    <= ty_13_reg;
            st_14_reg    <= st_13_reg;
            f14_reg      <= f13_reg;

            kr_15_reg    <= kr15_c.val;
            tx_15_reg    <= tx_14_reg;
            ty_15_reg    <= ty_14_reg;
            st_15_reg    <= st_14_reg;
            f15_reg      <= f14_reg | k3r6_c.clip | kr15_c.clip;

            psk_16_reg   <= smul(s_dl_reg[9], kr_15_reg);
            ptk_16_reg   <= smul(t_dl_reg[9], kr_15_reg);
            pp2tx_16_reg <= smul(p2_reg, tx_15_reg);
            pp1ty_16_reg <= smul(p1_reg, ty_15_reg);
            pp1st_16_reg <= smul(p1_reg, st_15_reg);
            pp2st_16_reg <= smul(p2_reg, st_15_reg);
            f16_reg      <= f15_reg;

            skr_17_reg   <= skr_c.val;
            tkr_17_reg   <= tkr_c.val;
            p2tx_17_reg  <= p2tx_c.val;
            p1ty_17_reg  <= p1ty_c.val;
            p1st_17_reg  <= p1st_c.val;
            p2st_17_reg  <= p2st_c.val;
            f17_reg      <= f16_reg | skr_c.clip | tkr_c.clip | p2tx_c.clip | p1ty_c.clip
                            | p1st_c.clip | p2st_c.clip;

            xd_18_reg    <= xd18_c.val;
            yd_18_reg    <= yd18_c.val;
            p2tx_18_reg  <= p2tx_17_reg;
            p1ty_18_reg  <= p1ty_17_reg;
            p1st_18_reg  <= p1st_17_reg;
            p2st_18_reg  <= p2st_17_reg;
            f18_reg      <= f17_reg | xd18_c.clip | yd18_c.clip;

            xd_19_reg    <= xd19_c.val;
            yd_19_reg    <= yd19_c.val;
            p1st_19_reg  <= p1st_18_reg;
            p2st_19_reg  <= p2st_18_reg;
            f19_reg      <= f18_reg | xd19_c.clip | yd19_c.clip;

            xd_20_reg    <= xd20_c.val;
            yd_20_reg    <= yd20_c.val;
            f20_reg      <= f19_reg | xd20_c.clip | yd20_c.clip;

            eu_21_reg    <= {xd_20_reg[31], xd_20_reg} + {1'b0, ONE_N};
            ev_21_reg    <= {yd_20_reg[31], yd_20_reg} + {1'b0, ONE_N};
            f21_reg      <= f20_reg;

            pu_22_reg    <= emul(eu_21_reg, center_x_reg);
            pv_22_reg    <= emul(ev_21_reg, center_y_reg);
            f22_reg      <= f21_reg;

            pu_23_reg    <= pu_c.val;
            pv_23_reg    <= pv_c.val;
            f23_reg      <= f22_reg | pu_c.clip | pv_c.clip;

            ru_reg       <= ru_c.val;
            rv_reg       <= rv_c.val;
            sat_out_reg  <= f23_reg | ru_c.clip | rv_c.clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlda_reg <= '0;
            vldb_reg <= '0;
            vldc_reg <= '0;
        end else if (adv) begin
            vlda_reg <= {vlda_reg[1:0], s_valid};
            vldb_reg <= {vldb_reg[0], d1u_valid & d1v_valid};
            vldc_reg <= {vldc_reg[17:0], d2u_valid & d2v_valid};
        end
    end

    assign m_residual_u = ru_reg;
    assign m_residual_v = rv_reg;
    assign m_saturated  = sat_out_reg;

endmodule

// ===== verif/tb_distorted_pinhole_residual.sv =====
// Testbench for distorted_pinhole_residual: random and directed points checked against a predictor.
module tb_distorted_pinhole_residual;
    import dpr_pkg::*;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] ou;
        logic [31:0] ov;
    } point_beat_t;

    typedef struct packed {
        logic [31:0] ru;
        logic [31:0] rv;
        logic        sat;
    } residual_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic [31:0] s_observed_u = '0, s_observed_v = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_residual_u, m_residual_v;
    logic        m_saturated;

    distorted_pinhole_residual i_dut (.*);

    always #4 aclk = ~aclk;

    logic [30:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
    logic [31:0] k1_q, k2_q, p1_q, p2_q;

    point_beat_t point_pend_q[$];
    residual_t   residual_expect_q[$];
    int          fail_count = 0;
    int          beats_in = 0, beats_out = 0, sat_seen = 0;
    bit          quiet = 1'b0;
    bit          hold_start = 1'b0;
    int          hold_cnt = 0;
    int          send_idle = 0, recv_idle = 0;
    longint      cycle_cnt = 0;

    function automatic longint clip32(input longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qprod(input longint a, input longint b, inout bit f);
        return clip32((a * b) >>> NORM_BITS, f);
    endfunction

    function automatic longint project_axis(input longint c, input longint fl,
                                            input longint p, input longint z, inout bit f);
        longint num;
        num = c * z + fl * p;
        if (z != 0) return clip32(num / z, f);
        return clip32(num >>> FRAC_BITS, f);
    endfunction

    function automatic longint normalize_axis(input longint up, input longint c, inout bit f);
        longint q;
        q = 0;
        if (c == 0) f = 1'b1;
        else q = (up <<< NORM_BITS) / c;
        return clip32(q - (64'sd1 <<< NORM_BITS), f);
    endfunction

    function automatic longint unscale_axis(input longint d, input longint c,
                                            input longint obs, inout bit f);
        longint p;
        p = clip32(((d + (64'sd1 <<< NORM_BITS)) * c) >>> NORM_BITS, f);
        return clip32(p - obs, f);
    endfunction

    function automatic residual_t predict_residual(input point_beat_t b);
        bit        f;
        longint    fx, fy, cx, cy, k1, k2, k3, p1, p2;
        longint    up, vp, s, t, x2, y2, r2, r4, r6, kr, st, tx, ty, xd, yd;
        residual_t r;
        f  = 1'b0;
        fx = longint'(focal_x_q);
        fy = longint'(focal_y_q);
        cx = longint'(center_x_q);
        cy = longint'(center_y_q);
        k1 = longint'($signed(k1_q));
        k2 = longint'($signed(k2_q));
        k3 = longint'($signed(SIXTH_ORDER_COEFF));
        p1 = longint'($signed(p1_q));
        p2 = longint'($signed(p2_q));
        up = project_axis(cx, fx, longint'($signed(b.px)), longint'($signed(b.pz)), f);
        vp = project_axis(cy, fy, longint'($signed(b.py)), longint'($signed(b.pz)), f);
        s  = normalize_axis(up, cx, f);
        t  = normalize_axis(vp, cy, f);
        x2 = qprod(s, s, f);
        y2 = qprod(t, t, f);
        r2 = clip32(x2 + y2, f);
        r4 = qprod(r2, r2, f);
        r6 = qprod(r2, r4, f);
        kr = clip32(qprod(k1, r2, f) + qprod(k2, r4, f), f);
        kr = clip32(kr + qprod(k3, r6, f), f);
        st = qprod(s, t, f);
        tx = clip32(r2 + 2 * x2, f);
        ty = clip32(r2 + 2 * y2, f);
        xd = clip32(s + qprod(s, kr, f), f);
        xd = clip32(xd + qprod(p2, tx, f), f);
        xd = clip32(xd + 2 * qprod(p1, st, f), f);
        yd = clip32(t + qprod(t, kr, f), f);
        yd = clip32(yd + qprod(p1, ty, f), f);
        yd = clip32(yd + 2 * qprod(p2, st, f), f);
        r.ru  = 32'(unscale_axis(xd, cx, longint'($signed(b.ou)), f));
        r.rv  = 32'(unscale_axis(yd, cy, longint'($signed(b.ov)), f));
        r.sat = f;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        point_beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                b = '{s_point_x, s_point_y, s_point_z, s_observed_u, s_observed_v};
                residual_expect_q.push_back(predict_residual(b));
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (point_pend_q.size() > 0) begin
                    b = point_pend_q.pop_front();
                    s_valid      <= 1'b1;
                    s_point_x    <= b.px;
                    s_point_y    <= b.py;
                    s_point_z    <= b.pz;
                    s_observed_u <= b.ou;
                    s_observed_v <= b.ov;
                    if (!quiet && $urandom_range(0, 5) == 0) send_idle = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) hold_cnt <= 0;
        else if (hold_start) hold_cnt <= 400;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // monitor
    always @(posedge aclk) begin
        residual_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (m_saturated) sat_seen++;
                if (residual_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result beat u=%h v=%h sat=%b",
                                                   m_residual_u, m_residual_v, m_saturated);
                end else begin
                    e = residual_expect_q.pop_front();
                    if (e.ru !== m_residual_u || e.rv !== m_residual_v
                        || e.sat !== m_saturated) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp u=%h v=%h sat=%b, got u=%h v=%h sat=%b",
                                     e.ru, e.rv, e.sat, m_residual_u, m_residual_v,
                                     m_saturated);
                    end
                end
            end
            if (hold_cnt != 0) begin
                m_ready <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) recv_idle = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > 400000) begin
            $display("timeout with %0d results outstanding", residual_expect_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FOCAL_X:  focal_x_q  = val[30:0];
            CFG_FOCAL_Y:  focal_y_q  = val[30:0];
            CFG_CENTER_X: center_x_q = val[30:0];
            CFG_CENTER_Y: center_y_q = val[30:0];
            CFG_K1:       k1_q = val;
            CFG_K2:       k2_q = val;
            CFG_P1:       p1_q = val;
            default:      p2_q = val;
        endcase
    endtask

    task automatic load_camera(input logic [31:0] fx, fy, cx, cy, k1, k2, p1, p2);
        cfg_write(CFG_FOCAL_X, fx);
        cfg_write(CFG_FOCAL_Y, fy);
        cfg_write(CFG_CENTER_X, cx);
        cfg_write(CFG_CENTER_Y, cy);
        cfg_write(CFG_K1, k1);
        cfg_write(CFG_K2, k2);
        cfg_write(CFG_P1, p1);
        cfg_write(CFG_P2, p2);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (point_pend_q.size() != 0 || s_valid || residual_expect_q.size() != 0
               || send_idle != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic queue_point(input logic [31:0] x, y, z, u, v);
        point_pend_q.push_back('{x, y, z, u, v});
    endtask

    task automatic queue_random(input int n);
        int z, x, y;
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_point($urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                z = $urandom_range(32'h8000, 32'd200 << 16);
                x = int'($urandom_range(0, z)) - z / 2;
                y = int'($urandom_range(0, z)) - z / 2;
                if ($urandom_range(0, 7) == 0) z = -z;
                queue_point(x, y, z, $urandom_range(0, 32'd640 << 16),
                            $urandom_range(0, 32'd640 << 16));
            end
        end
    endtask

    task automatic load_random_camera();
        load_camera($urandom_range(32'd100 << 16, 32'd2000 << 16),
                    $urandom_range(32'd100 << 16, 32'd2000 << 16),
                    $urandom_range(32'd100 << 16, 32'd1000 << 16),
                    $urandom_range(32'd100 << 16, 32'd1000 << 16),
                    $urandom_range(0, 32'h1000_0000) - 32'h0800_0000,
                    $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                    $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                    $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
    endtask

    initial begin
        focal_x_q  = FOCAL_RST;
        focal_y_q  = FOCAL_RST;
        center_x_q = CENTER_RST;
        center_y_q = CENTER_RST;
        k1_q = '0;
        k2_q = '0;
        p1_q = '0;
        p2_q = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset camera
        queue_point(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        queue_point(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1);
        queue_point(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_point(32'h0001_0000, 32'h0001_0000, 32'h000A_0000, 32'h0140_0000, 32'h0140_0000);
        queue_random(6);
        drain();

        // distortion on, zero center, then extreme registers
        load_camera(32'd500 << 16, 32'd500 << 16, 32'd320 << 16, 32'd240 << 16,
                    32'hF800_0000, 32'h0100_0000, 32'h0010_0000, 32'hFFF0_0000);
        queue_random(8);
        drain();
        load_camera(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000);
        queue_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0);
        queue_random(8);
        drain();
        load_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_random(30);
        drain();
        load_camera(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_random(30);
        drain();

        // fill the pipeline against a held receiver
        load_random_camera();
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        queue_random(80);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2) load_camera($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom);
            else load_random_camera();
            if (ph == 4) quiet = 1'b1;
            queue_random(50);
            drain();
        end

        $display("%0d point beats in, %0d residual beats out, %0d saturated, %0d mismatches",
                 beats_in, beats_out, sat_seen, fail_count);
        $display("covered reset, distorted, zero-center and full-scale cameras under stalls");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/dpr_pkg.sv
sv/dpr_div.sv
sv/distorted_pinhole_residual.sv
verif/tb_distorted_pinhole_residual.sv
